>>> hdl/hsc_pkg.sv
`timescale 1ns / 1ps

package hsc_pkg;

  // field and register widths
  localparam int ELEV_BITS = 24;
  localparam int FRAC_BITS = 16;
  localparam int CELL_BITS = 20;
  localparam int CFG_DW    = (ELEV_BITS > CELL_BITS) ? ELEV_BITS : CELL_BITS;

  // gradient triple is scaled so its largest magnitude has this many bits
  localparam int NORM_BITS = 26;

  // 2*sqrt(2) in Q30
  localparam logic [31:0] TWO_ROOT2_Q30 = 32'd3037000500;

  // smallest usable span, one metre
  localparam int SPAN_MIN = 16;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MIN_ELEV  = 2'd0;
  localparam cfg_idx_t CFG_ELEV_SPAN = 2'd1;
  localparam cfg_idx_t CFG_CELL_SIZE = 2'd2;

  typedef struct packed {
    logic signed [ELEV_BITS-1:0] centre_elevation;
    logic signed [ELEV_BITS-1:0] east_elevation;
    logic signed [ELEV_BITS-1:0] west_elevation;
    logic signed [ELEV_BITS-1:0] up_elevation;
    logic signed [ELEV_BITS-1:0] down_elevation;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_t;

  // ramp stop positions in thousandths
  function automatic logic [9:0] ramp_pm(input logic [2:0] idx);
    logic [9:0] v;
    unique case (idx)
      3'd0:    v = 10'd0;
      3'd1:    v = 10'd300;
      3'd2:    v = 10'd580;
      3'd3:    v = 10'd800;
      default: v = 10'd1000;
    endcase
    return v;
  endfunction

  // segment width in thousandths
  function automatic logic [8:0] ramp_width(input logic [1:0] k);
    logic [8:0] v;
    unique case (k)
      2'd0:    v = 9'd300;
      2'd1:    v = 9'd280;
      2'd2:    v = 9'd220;
      default: v = 9'd200;
    endcase
    return v;
  endfunction

  // floor(2^20 / segment width)
  function automatic logic [12:0] ramp_recip(input logic [1:0] k);
    logic [12:0] v;
    unique case (k)
      2'd0:    v = 13'd3495;
      2'd1:    v = 13'd3744;
      2'd2:    v = 13'd4766;
      default: v = 13'd5242;
    endcase
    return v;
  endfunction

  // stop colours, channel 0 red, 1 green, 2 blue
  function automatic logic [7:0] ramp_rgb(input logic [2:0] idx, input logic [1:0] ch);
    logic [23:0] rgb;
    logic [7:0]  v;
    unique case (idx)
      3'd0:    rgb = {8'd58,  8'd92,  8'd62};
      3'd1:    rgb = {8'd96,  8'd120, 8'd66};
      3'd2:    rgb = {8'd150, 8'd134, 8'd88};
      3'd3:    rgb = {8'd146, 8'd126, 8'd112};
      default: rgb = {8'd242, 8'd242, 8'd246};
    endcase
    unique case (ch)
      2'd0:    v = rgb[23:16];
      2'd1:    v = rgb[15:8];
      default: v = rgb[7:0];
    endcase
    return v;
  endfunction

endpackage

>>> hdl/terrain_hillshade_colour_core.sv
`timescale 1ns / 1ps

// channel  direction  handshake              payload
// in_      input      in_valid / in_ready    hsc_pkg::in_t, five elevations
// out_     output     out_valid / out_ready  hsc_pkg::out_t, red green blue
// cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item per cycle while the output is not stalled; the square root, one result bit
// per stage, is followed by the restoring shade divider, one quotient bit per stage.
// reset is synchronous and clears the valid bits and sets the configuration
// registers to defaults. a stalled output freezes the whole pipeline; nothing is
// dropped or repeated.
module terrain_hillshade_colour_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  hsc_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output hsc_pkg::out_t                out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  hsc_pkg::cfg_idx_t            cfg_index,
  input  logic [hsc_pkg::CFG_DW-1:0]   cfg_data
);

  localparam int EB    = hsc_pkg::ELEV_BITS;
  localparam int FB    = hsc_pkg::FRAC_BITS;
  localparam int CB    = hsc_pkg::CELL_BITS;
  localparam int NB    = hsc_pkg::NORM_BITS;
  localparam int MW    = (EB + 1 > CB + 1) ? EB + 1 : CB + 1;
  localparam int XW    = MW + NB;
  localparam int PMW   = $clog2(MW);
  localparam int SHW   = $clog2(XW);
  localparam int SQ_N  = NB + 2;
  localparam int RW    = 2 * SQ_N;
  localparam int TCW   = NB + 2 + FB;
  localparam int NUMW  = NB + 4 + FB;
  localparam int REMW  = NUMW - 1;
  localparam int DENW  = SQ_N + 1;
  localparam int QB    = FB + 1;
  localparam int TW    = FB + 1;
  localparam int T1W   = FB + 10;
  localparam int PW    = FB + 9;
  localparam int AW    = PW + 8;
  localparam int YW    = 16;
  localparam int RS    = 20;
  localparam int M2W   = YW + 13;
  localparam int FW    = FB + 7;
  localparam int PRW   = FW + 8;
  localparam int FYW   = 15;
  localparam int RS2   = 21;
  localparam int R100  = (1 << RS2) / 100;
  localparam longint ONE_L = longint'(1) << FB;

  localparam int ROOT_ST   = 5 + SQ_N;
  localparam int FACT_ST   = ROOT_ST + QB + 3;
  localparam int OUT_ST    = FACT_ST + 3;
  localparam int BASE_ST   = FB + 6;
  localparam int DLY       = FACT_ST - BASE_ST;

  localparam logic [T1W-1:0] STOP1 = T1W'(longint'(hsc_pkg::ramp_pm(3'd1)) * ONE_L);
  localparam logic [T1W-1:0] STOP2 = T1W'(longint'(hsc_pkg::ramp_pm(3'd2)) * ONE_L);
  localparam logic [T1W-1:0] STOP3 = T1W'(longint'(hsc_pkg::ramp_pm(3'd3)) * ONE_L);

  // configuration registers
  logic signed [EB-1:0] min_elev_r;
  logic [EB-1:0]        span_r;
  logic [CB-1:0]        cell_r;
  logic [CB-1:0]        c_eff;
  logic [EB-1:0]        span_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_elev_r <= '0;
      span_r     <= EB'(16);
      cell_r     <= CB'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hsc_pkg::CFG_MIN_ELEV:  min_elev_r <= $signed(cfg_data[EB-1:0]);
        hsc_pkg::CFG_ELEV_SPAN: span_r     <= cfg_data[EB-1:0];
        hsc_pkg::CFG_CELL_SIZE: cell_r     <= cfg_data[CB-1:0];
        default: ;
      endcase
    end
  end

  // zero cell and small span substitutes
  assign c_eff    = (cell_r == '0) ? CB'(1) : cell_r;
  assign span_eff = (span_r < EB'(hsc_pkg::SPAN_MIN)) ? EB'(hsc_pkg::SPAN_MIN) : span_r;

  // pipeline advance and valid bits
  logic [OUT_ST:0] vld_r;
  logic            ce;

  assign ce        = !vld_r[OUT_ST] || out_ready;
  assign in_ready  = ce;
  assign out_valid = vld_r[OUT_ST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[OUT_ST-1:0], in_valid};
    end
  end

  // stage 0: differences
  logic signed [EB:0] s0_dx_r, s0_dy_r, s0_diff_r;
  logic signed [EB:0] s0_dx_nxt, s0_dy_nxt, s0_diff_nxt;

  always_comb begin
    s0_dx_nxt   = (EB+1)'($signed(in_data.east_elevation)) -
                  (EB+1)'($signed(in_data.west_elevation));
    s0_dy_nxt   = (EB+1)'($signed(in_data.up_elevation)) -
                  (EB+1)'($signed(in_data.down_elevation));
    s0_diff_nxt = (EB+1)'($signed(in_data.centre_elevation)) - (EB+1)'(min_elev_r);
  end

  // stage 1: magnitudes, largest term, t saturation
  logic [MW-1:0] s1_ax_r, s1_ay_r, s1_m_r;
  logic          s1_sx_r, s1_sy_r;
  logic [MW-1:0] s1_ax_nxt, s1_ay_nxt, s1_m_nxt, twoc;

  logic [EB:0]   tr_rem_r [FB+1];
  logic [FB-1:0] tr_q_r   [FB+1];
  logic          tr_z_r   [FB+1];
  logic          tr_one_r [FB+1];
  logic [EB:0]   tr_rem_nxt [FB];
  logic [FB-1:0] tr_q_nxt   [FB];

  always_comb begin
    s1_ax_nxt = MW'(s0_dx_r[EB] ? -s0_dx_r : s0_dx_r);
    s1_ay_nxt = MW'(s0_dy_r[EB] ? -s0_dy_r : s0_dy_r);
    twoc      = MW'({c_eff, 1'b0});
    s1_m_nxt  = twoc;
    if (s1_ax_nxt > s1_m_nxt) s1_m_nxt = s1_ax_nxt;
    if (s1_ay_nxt > s1_m_nxt) s1_m_nxt = s1_ay_nxt;
  end

  // stage 2: leading one of the largest term
  logic [PMW-1:0] p_nxt;
  logic           s2_rsh_r;
  logic [SHW-1:0] s2_sh_r;
  logic [MW-1:0]  s2_ax_r, s2_ay_r;
  logic           s2_sx_r, s2_sy_r;

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < MW; i++) begin
      if (s1_m_r[i]) p_nxt = PMW'(i);
    end
  end

  // stage 3: scale so the largest term sits just under 2^NB
  logic [NB-1:0] s3_axn_r, s3_ayn_r, s3_cn_r;
  logic          s3_sx_r, s3_sy_r;

  // stage 4: squares and light term product
  logic [RW-1:0]     s4_c2_r, s4_x2_r, s4_y2_r;
  logic [NB+31:0]    s4_tp_r;
  logic signed [NB:0] s4_dxn_r, s4_dyn_r;

  // stage 5: radicand and shade numerator
  logic [RW-1:0]            d_nxt;
  logic [TCW-1:0]           tc;
  logic signed [NB+1:0]     dxy;
  logic signed [NUMW-1:0]   num_nxt;

  always_comb begin
    d_nxt   = s4_c2_r + s4_x2_r + s4_y2_r;
    tc      = TCW'(s4_tp_r >> (30 - FB));
    dxy     = (NB+2)'(s4_dxn_r) + (NB+2)'(s4_dyn_r);
    num_nxt = $signed(NUMW'(tc)) + (NUMW'(dxy) <<< FB);
  end

  // square root, one result bit per stage
  logic [RW-1:0]          sq_x_r   [SQ_N+1];
  logic [RW-1:0]          sq_rt_r  [SQ_N+1];
  logic signed [NUMW-1:0] sq_num_r [SQ_N+1];
  logic [RW-1:0]          sq_x_nxt  [SQ_N];
  logic [RW-1:0]          sq_rt_nxt [SQ_N];

  always_comb begin
    logic [RW-1:0] bitc, trial;
    for (int i = 0; i < SQ_N; i++) begin
      bitc  = RW'(1) << (2 * (SQ_N - 1 - i));
      trial = sq_rt_r[i] + bitc;
      if (sq_x_r[i] >= trial) begin
        sq_x_nxt[i]  = sq_x_r[i] - trial;
        sq_rt_nxt[i] = (sq_rt_r[i] >> 1) + bitc;
      end else begin
        sq_x_nxt[i]  = sq_x_r[i];
        sq_rt_nxt[i] = sq_rt_r[i] >> 1;
      end
    end
  end

  // divider setup: denominator, sign and overflow of the quotient
  logic [DENW-1:0] den_nxt;
  logic            npos_nxt, sat_nxt;
  logic [REMW-1:0] numu;

  always_comb begin
    den_nxt  = DENW'({sq_rt_r[SQ_N], 1'b0});
    npos_nxt = !sq_num_r[SQ_N][NUMW-1] && (sq_num_r[SQ_N] != '0);
    numu     = sq_num_r[SQ_N][NUMW-2:0];
    sat_nxt  = NUMW'(numu) >= (NUMW'(den_nxt) << QB);
  end

  // restoring divider, one quotient bit per stage
  logic [REMW-1:0] dv_rem_r [QB+1];
  logic [QB-1:0]   dv_q_r   [QB+1];
  logic [DENW-1:0] dv_den_r [QB+1];
  logic            dv_pos_r [QB+1];
  logic            dv_sat_r [QB+1];
  logic [REMW-1:0] dv_rem_nxt [QB];
  logic [QB-1:0]   dv_q_nxt   [QB];

  always_comb begin
    logic [REMW-1:0] dsh;
    for (int j = 0; j < QB; j++) begin
      dsh = REMW'(dv_den_r[j]) << (QB - 1 - j);
      if (dv_rem_r[j] >= dsh) begin
        dv_rem_nxt[j] = dv_rem_r[j] - dsh;
        dv_q_nxt[j]   = {dv_q_r[j][QB-2:0], 1'b1};
      end else begin
        dv_rem_nxt[j] = dv_rem_r[j];
        dv_q_nxt[j]   = {dv_q_r[j][QB-2:0], 1'b0};
      end
    end
  end

  // t divider steps
  always_comb begin
    logic [EB:0] dbl;
    for (int j = 0; j < FB; j++) begin
      dbl = {tr_rem_r[j][EB-1:0], 1'b0};
      if (dbl >= {1'b0, span_eff}) begin
        tr_rem_nxt[j] = dbl - {1'b0, span_eff};
        tr_q_nxt[j]   = {tr_q_r[j][FB-2:0], 1'b1};
      end else begin
        tr_rem_nxt[j] = dbl;
        tr_q_nxt[j]   = {tr_q_r[j][FB-2:0], 1'b0};
      end
    end
  end

  // ramp: t, segment and position
  logic [TW-1:0]  c1_t_r;
  logic [1:0]     c2_k_r;
  logic [PW-1:0]  c2_pos_r;
  logic [T1W-1:0] t1000;
  logic [1:0]     k_nxt;
  logic [PW-1:0]  pos_nxt;

  always_comb begin
    t1000 = T1W'(c1_t_r) * T1W'(1000);
    priority if (t1000 <= STOP1) k_nxt = 2'd0;
    else if (t1000 <= STOP2)     k_nxt = 2'd1;
    else if (t1000 <= STOP3)     k_nxt = 2'd2;
    else                         k_nxt = 2'd3;
    pos_nxt = PW'(t1000 - (T1W'(hsc_pkg::ramp_pm({1'b0, k_nxt})) << FB));
  end

  // ramp: per channel interpolation
  logic [2:0][AW-1:0]  c3_a_r;
  logic [2:0]          c3_neg_r;
  logic [1:0]          c3_k_r;
  logic [2:0][AW-1:0]  c3_a_nxt;
  logic [2:0]          c3_neg_nxt;
  logic [2:0][YW-1:0]  c4_y_r;
  logic [2:0][M2W-1:0] c4_m_r;
  logic [2:0]          c4_neg_r;
  logic [1:0]          c4_k_r;
  logic [2:0][YW-1:0]  c4_y_nxt;
  logic [2:0][M2W-1:0] c4_m_nxt;
  logic [2:0][7:0]     base_nxt;
  logic [2:0][7:0]     bd_r [DLY+1];

  always_comb begin
    logic [7:0] lo, hi, mag;
    for (int ch = 0; ch < 3; ch++) begin
      lo             = hsc_pkg::ramp_rgb({1'b0, c2_k_r}, 2'(ch));
      hi             = hsc_pkg::ramp_rgb(3'({1'b0, c2_k_r}) + 3'd1, 2'(ch));
      c3_neg_nxt[ch] = hi < lo;
      mag            = c3_neg_nxt[ch] ? lo - hi : hi - lo;
      c3_a_nxt[ch]   = AW'(c2_pos_r) * AW'(mag);
    end
  end

  // divide by the segment width through its reciprocal
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (c3_neg_r[ch]) begin
        c4_y_nxt[ch] = YW'((c3_a_r[ch] + AW'(ONE_L - 1)) >> FB) +
                       YW'(hsc_pkg::ramp_width(c3_k_r)) - YW'(1);
      end else begin
        c4_y_nxt[ch] = YW'(c3_a_r[ch] >> FB);
      end
      c4_m_nxt[ch] = M2W'(c4_y_nxt[ch]) * M2W'(hsc_pkg::ramp_recip(c3_k_r));
    end
  end

  always_comb begin
    logic [YW-1:0] q, wd;
    logic [7:0]    lo;
    for (int ch = 0; ch < 3; ch++) begin
      wd = YW'(hsc_pkg::ramp_width(c4_k_r));
      q  = YW'(c4_m_r[ch] >> RS);
      if (c4_y_r[ch] - YW'(q * wd) >= wd) q = q + YW'(1);
      lo = hsc_pkg::ramp_rgb({1'b0, c4_k_r}, 2'(ch));
      base_nxt[ch] = c4_neg_r[ch] ? lo - q[7:0] : lo + q[7:0];
    end
  end

  // shade clamp and brightness scale
  logic [TW-1:0]        shade_r, shade_nxt;
  logic [FW-1:0]        fac_r;
  logic [2:0][PRW-1:0]  pr_r;
  logic [2:0][FYW-1:0]  fy_r;
  logic [2:0][2*FYW-1:0] fm_r;
  logic [2:0][FYW-1:0]  fy_nxt;
  hsc_pkg::out_t        out_r, out_nxt;

  always_comb begin
    if (!dv_pos_r[QB]) begin
      shade_nxt = '0;
    end else if (dv_sat_r[QB] || (dv_q_r[QB] > TW'(ONE_L))) begin
      shade_nxt = TW'(ONE_L);
    end else begin
      shade_nxt = dv_q_r[QB];
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      fy_nxt[ch] = FYW'(pr_r[ch] >> FB);
    end
  end

  // final divide by 100 through its reciprocal
  always_comb begin
    logic [FYW:0] q;
    logic [2:0][7:0] v;
    for (int ch = 0; ch < 3; ch++) begin
      q = (FYW+1)'(fm_r[ch] >> RS2);
      if ((FYW+1)'(fy_r[ch]) - (FYW+1)'(q * (FYW+1)'(100)) >= (FYW+1)'(100)) begin
        q = q + (FYW+1)'(1);
      end
      v[ch] = q[7:0];
    end
    out_nxt.red   = v[0];
    out_nxt.green = v[1];
    out_nxt.blue  = v[2];
  end

  assign out_data = out_r;

  // payload registers
  always_ff @(posedge clk) begin
    if (ce) begin
      s0_dx_r   <= s0_dx_nxt;
      s0_dy_r   <= s0_dy_nxt;
      s0_diff_r <= s0_diff_nxt;

      s1_ax_r <= s1_ax_nxt;
      s1_ay_r <= s1_ay_nxt;
      s1_m_r  <= s1_m_nxt;
      s1_sx_r <= s0_dx_r[EB];
      s1_sy_r <= s0_dy_r[EB];

      tr_rem_r[0] <= {1'b0, s0_diff_r[EB-1:0]};
      tr_q_r[0]   <= '0;
      tr_z_r[0]   <= s0_diff_r <= 0;
      tr_one_r[0] <= s0_diff_r >= $signed({1'b0, span_eff});
      for (int j = 0; j < FB; j++) begin
        tr_rem_r[j+1] <= tr_rem_nxt[j];
        tr_q_r[j+1]   <= tr_q_nxt[j];
        tr_z_r[j+1]   <= tr_z_r[j];
        tr_one_r[j+1] <= tr_one_r[j];
      end

      s2_rsh_r <= p_nxt > PMW'(NB - 1);
      s2_sh_r  <= (p_nxt > PMW'(NB - 1)) ? SHW'(p_nxt - PMW'(NB - 1))
                                         : SHW'(PMW'(NB - 1) - p_nxt);
      s2_ax_r  <= s1_ax_r;
      s2_ay_r  <= s1_ay_r;
      s2_sx_r  <= s1_sx_r;
      s2_sy_r  <= s1_sy_r;

      s3_axn_r <= s2_rsh_r ? NB'(XW'(s2_ax_r) >> s2_sh_r) : NB'(XW'(s2_ax_r) << s2_sh_r);
      s3_ayn_r <= s2_rsh_r ? NB'(XW'(s2_ay_r) >> s2_sh_r) : NB'(XW'(s2_ay_r) << s2_sh_r);
      s3_cn_r  <= s2_rsh_r ? NB'(XW'(c_eff) >> s2_sh_r) : NB'(XW'(c_eff) << s2_sh_r);
      s3_sx_r  <= s2_sx_r;
      s3_sy_r  <= s2_sy_r;

      s4_c2_r  <= RW'({s3_cn_r, 1'b0}) * RW'({s3_cn_r, 1'b0});
      s4_x2_r  <= RW'(s3_axn_r) * RW'(s3_axn_r);
      s4_y2_r  <= RW'(s3_ayn_r) * RW'(s3_ayn_r);
      s4_tp_r  <= (NB+32)'(s3_cn_r) * (NB+32)'(hsc_pkg::TWO_ROOT2_Q30);
      s4_dxn_r <= s3_sx_r ? -$signed({1'b0, s3_axn_r}) : $signed({1'b0, s3_axn_r});
      s4_dyn_r <= s3_sy_r ? -$signed({1'b0, s3_ayn_r}) : $signed({1'b0, s3_ayn_r});

      sq_x_r[0]   <= d_nxt;
      sq_rt_r[0]  <= '0;
      sq_num_r[0] <= num_nxt;
      for (int i = 0; i < SQ_N; i++) begin
        sq_x_r[i+1]   <= sq_x_nxt[i];
        sq_rt_r[i+1]  <= sq_rt_nxt[i];
        sq_num_r[i+1] <= sq_num_r[i];
      end

      dv_rem_r[0] <= numu;
      dv_q_r[0]   <= '0;
      dv_den_r[0] <= den_nxt;
      dv_pos_r[0] <= npos_nxt;
      dv_sat_r[0] <= sat_nxt;
      for (int j = 0; j < QB; j++) begin
        dv_rem_r[j+1] <= dv_rem_nxt[j];
        dv_q_r[j+1]   <= dv_q_nxt[j];
        dv_den_r[j+1] <= dv_den_r[j];
        dv_pos_r[j+1] <= dv_pos_r[j];
        dv_sat_r[j+1] <= dv_sat_r[j];
      end

      c1_t_r   <= tr_z_r[FB] ? '0 : (tr_one_r[FB] ? TW'(ONE_L) : TW'(tr_q_r[FB]));
      c2_k_r   <= k_nxt;
      c2_pos_r <= pos_nxt;
      c3_a_r   <= c3_a_nxt;
      c3_neg_r <= c3_neg_nxt;
      c3_k_r   <= c2_k_r;
      c4_y_r   <= c4_y_nxt;
      c4_m_r   <= c4_m_nxt;
      c4_neg_r <= c3_neg_r;
      c4_k_r   <= c3_k_r;
      bd_r[0]  <= base_nxt;
      for (int i = 0; i < DLY; i++) begin
        bd_r[i+1] <= bd_r[i];
      end

      shade_r <= shade_nxt;
      fac_r   <= FW'(35 * ONE_L) + FW'(shade_r) * FW'(65);
      for (int ch = 0; ch < 3; ch++) begin
        pr_r[ch] <= PRW'(bd_r[DLY][ch]) * PRW'(fac_r);
        fy_r[ch] <= fy_nxt[ch];
        fm_r[ch] <= (2*FYW)'(fy_nxt[ch]) * (2*FYW)'(R100);
      end
      out_r <= out_nxt;
    end
  end

endmodule

>>> hdl/hsc_checker.sv
`timescale 1ns / 1ps

module hsc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input hsc_pkg::out_t out_data
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an empty output stage never blocks the input
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // a stall at the output reaches the input in the same cycle
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind terrain_hillshade_colour_core hsc_checker u_hsc_checker (.*);
